// ===== rtl/core/ubx_ffe_pkg.sv =====
`default_nettype none

package ubx_ffe_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_SKIP   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		KIND_OTHER         = 3'd0,
		KIND_SATS          = 3'd1,
		KIND_TIME_VALID    = 3'd2,
		KIND_TIME_INVALID  = 3'd3,
		KIND_TIME_SHORT    = 3'd4,
		KIND_VERSION       = 3'd5,
		KIND_VERSION_SHORT = 3'd6
	} frame_kind_t;

	typedef enum logic [1:0] {
		REQ_NONE      = 2'd0,
		REQ_TIME      = 2'd1,
		REQ_TIME_SATS = 2'd2,
		REQ_VERSION   = 2'd3
	} request_t;

	localparam int unsigned POS_W = 17;

	localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
	localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
	localparam logic [7:0] CLASS_NAV   = 8'h01;
	localparam logic [7:0] CLASS_MON   = 8'h0A;
	localparam logic [7:0] ID_SVINFO   = 8'h35;
	localparam logic [7:0] ID_TIMEUTC  = 8'h21;
	localparam logic [7:0] ID_VER      = 8'h04;
	localparam logic [7:0] NEWLINE     = 8'h0A;

	localparam logic [POS_W-1:0] HDR_LAST    = 17'd5;
	localparam logic [POS_W-1:0] BODY_START  = 17'd6;
	localparam logic [POS_W-1:0] FRAME_EXTRA = 17'd8;
	localparam logic [POS_W-1:0] OFS_SATS    = 17'd11;
	localparam logic [POS_W-1:0] OFS_DT      = 17'd18;
	localparam logic [POS_W-1:0] OFS_DT_LAST = 17'd23;
	localparam logic [POS_W-1:0] OFS_FLAGS   = 17'd25;
	localparam logic [POS_W-1:0] OFS_VER     = 17'd36;
	localparam logic [POS_W-1:0] OFS_VER_END = 17'd43;
	localparam logic [POS_W-1:0] TIME_MIN    = 17'd26;
	localparam logic [POS_W-1:0] VER_MIN     = 17'd45;

	localparam int unsigned TIME_GOOD_BIT = 2;

endpackage

`default_nettype wire

// ===== rtl/core/ubx_frame_field_extractor_unit.sv =====
`default_nettype none

// Byte-stream parser for binary receiver frames. One byte is taken per cycle
// with no gaps needed while the result is not stalled; each byte passes an
// input register and the per-byte state update; a frame result is registered
// when the state update takes its last byte. The result register is the only
// place that can hold the input back: a stalled result stops the byte stage.
// Once a valid timestamp has been reported the block keeps accepting bytes
// but drops them and gives no further results.
module ubx_frame_field_extractor_unit
	import ubx_ffe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       frame_kind,
	output logic [1:0]       request,
	output logic [7:0]       sat_count,
	output logic [7:0]       time_flags,
	output logic [15:0]      year_value,
	output logic [7:0]       month_value,
	output logic [7:0]       day_value,
	output logic [7:0]       hour_value,
	output logic [7:0]       minute_value,
	output logic [63:0]      version_text,
	output logic             logging_started
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv;

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] total_q, total_d;
	logic [7:0]       first_q, first_d;
	logic             sync_q, sync_d;
	logic [7:0]       class_q, class_d;
	logic [7:0]       id_q, id_d;
	logic [7:0]       len_lo_q, len_lo_d;
	logic [7:0]       sats_q, sats_d;
	logic [7:0]       flags_q, flags_d;
	logic [47:0]      dt_q, dt_d;
	logic [63:0]      ver_q, ver_d;
	logic             log_q, log_d;

	logic             done;
	frame_kind_t      kind;
	request_t         req;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] dt_rel;
	logic [POS_W-1:0] ver_rel;
	logic             is_sats, is_time, is_ver;

	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic [1:0]       req_q;
	logic [7:0]       sats_out_q;
	logic [7:0]       flags_out_q;
	logic [47:0]      dt_out_q;
	logic [63:0]      ver_out_q;
	logic             log_out_q;

	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign is_sats = (class_q == CLASS_NAV) && (id_q == ID_SVINFO);
	assign is_time = (class_q == CLASS_NAV) && (id_q == ID_TIMEUTC);
	assign is_ver  = (class_q == CLASS_MON) && (id_q == ID_VER);
	assign pos_inc = pos_q + 17'd1;
	assign dt_rel  = pos_q - OFS_DT;
	assign ver_rel = pos_q - OFS_VER;

	// per-byte state update
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		total_d  = total_q;
		first_d  = first_q;
		sync_d   = sync_q;
		class_d  = class_q;
		id_d     = id_q;
		len_lo_d = len_lo_q;
		sats_d   = sats_q;
		flags_d  = flags_q;
		dt_d     = dt_q;
		ver_d    = ver_q;
		log_d    = log_q;
		done     = 1'b0;
		if (!log_q) begin
			case (phase_q)
				PH_SKIP: begin
					if (byte_s1 == NEWLINE) begin
						phase_d = PH_HEADER;
						pos_d   = '0;
					end
				end
				PH_HEADER: begin
					case (pos_q[2:0])
						3'd0: first_d  = byte_s1;
						3'd1: sync_d   = (first_q == SYNC_CHAR_1) && (byte_s1 == SYNC_CHAR_2);
						3'd2: class_d  = byte_s1;
						3'd3: id_d     = byte_s1;
						3'd4: len_lo_d = byte_s1;
						default: ;
					endcase
					if (pos_q == HDR_LAST) begin
						if (sync_q) begin
							total_d = {9'd0, len_lo_q} + {1'b0, byte_s1, 8'd0} + FRAME_EXTRA;
							phase_d = PH_BODY;
							pos_d   = BODY_START;
						end else begin
							phase_d = PH_SKIP;
							pos_d   = '0;
						end
					end else begin
						pos_d = pos_inc;
					end
				end
				PH_BODY: begin
					if (is_sats) begin
						if (pos_q == OFS_SATS) begin
							sats_d = byte_s1;
						end
					end else if (is_time) begin
						if (pos_q >= OFS_DT && pos_q <= OFS_DT_LAST) begin
							dt_d[{dt_rel[2:0], 3'b000} +: 8] = byte_s1;
						end else if (pos_q == OFS_FLAGS) begin
							flags_d = byte_s1;
						end
					end else if (is_ver) begin
						if (pos_q >= OFS_VER && pos_q <= OFS_VER_END) begin
							ver_d[{ver_rel[2:0], 3'b000} +: 8] = byte_s1;
						end
					end
					pos_d = pos_inc;
					if (pos_inc >= total_q) begin
						done    = 1'b1;
						phase_d = PH_HEADER;
						pos_d   = '0;
					end
				end
				default: begin
					phase_d = PH_HEADER;
					pos_d   = '0;
				end
			endcase
		end
		kind = KIND_OTHER;
		req  = REQ_NONE;
		if (is_sats) begin
			kind = KIND_SATS;
		end else if (is_time) begin
			if (total_q < TIME_MIN) begin
				kind = KIND_TIME_SHORT;
				req  = REQ_TIME;
			end else if (flags_d[TIME_GOOD_BIT]) begin
				kind = KIND_TIME_VALID;
				if (done) begin
					log_d = 1'b1;
				end
			end else begin
				kind = KIND_TIME_INVALID;
				req  = REQ_TIME_SATS;
			end
		end else if (is_ver) begin
			if (total_q < VER_MIN) begin
				kind = KIND_VERSION_SHORT;
				req  = REQ_VERSION;
			end else begin
				kind = KIND_VERSION;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			total_q  <= '0;
			first_q  <= '0;
			sync_q   <= 1'b0;
			class_q  <= '0;
			id_q     <= '0;
			len_lo_q <= '0;
			sats_q   <= '0;
			flags_q  <= '0;
			dt_q     <= '0;
			ver_q    <= '0;
			log_q    <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			total_q  <= total_d;
			first_q  <= first_d;
			sync_q   <= sync_d;
			class_q  <= class_d;
			id_q     <= id_d;
			len_lo_q <= len_lo_d;
			sats_q   <= sats_d;
			flags_q  <= flags_d;
			dt_q     <= dt_d;
			ver_q    <= ver_d;
			log_q    <= log_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done) begin
			kind_q      <= kind;
			req_q       <= req;
			sats_out_q  <= sats_d;
			flags_out_q <= flags_d;
			dt_out_q    <= dt_d;
			ver_out_q   <= ver_d;
			log_out_q   <= log_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_kind      = kind_q;
	assign request         = req_q;
	assign sat_count       = sats_out_q;
	assign time_flags      = flags_out_q;
	assign year_value      = dt_out_q[15:0];
	assign month_value     = dt_out_q[23:16];
	assign day_value       = dt_out_q[31:24];
	assign hour_value      = dt_out_q[39:32];
	assign minute_value    = dt_out_q[47:40];
	assign version_text    = ver_out_q;
	assign logging_started = log_out_q;

	a_log_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		log_q |=> log_q)
		else $error("logging mode dropped");

	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (pos_q <= HDR_LAST))
		else $error("header position out of range");

	a_body_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (pos_q < total_q))
		else $error("body position beyond frame end");

	a_skip_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (pos_q == '0))
		else $error("position not cleared while skipping");

endmodule

`default_nettype wire
